// ===== hw/rtl/plq_pkg.sv =====
// Shared types and codes for the price level order queue.
// Depends on nothing; used by plq_cell and price_level_order_queue_core.
package plq_pkg;

    localparam int IdW    = 31;
    localparam int PriceW = 32;
    localparam int QtyW   = 31;
    localparam int TotW   = 37;
    localparam logic [TotW-1:0] TotMax = {TotW{1'b1}};

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_MODIFY = 3'd2,
        KIND_DEC    = 3'd3,
        KIND_FIND   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOOKUP,
        PH_APPLY,
        PH_OUT
    } phase_t;

    // One slot's contents as handed along the chain.
    typedef struct packed {
        logic [IdW-1:0]    id;
        logic [PriceW-1:0] price;
        logic [QtyW-1:0]   qty;
    } entry_t;

    // Command broadcast to every cell in the apply cycle.
    typedef struct packed {
        logic       shift;    // cells at or past gap take the right neighbor
        logic       write_q;  // cell at pos overwrites its quantity
        logic       append;   // cell at tail index loads new entry
    } cell_cmd_t;

endpackage

// ===== hw/rtl/plq_cell.sv =====
// One slot of the order chain: holds an entry, compares its id, shifts left.
// Depends on plq_pkg.
module plq_cell (
    input  logic                 aclk,
    input  logic                 is_pos,
    input  logic                 past_pos,
    input  logic                 is_tail,
    input  plq_pkg::cell_cmd_t   cmd,
    input  plq_pkg::entry_t      new_entry,
    input  plq_pkg::entry_t      right_entry,
    input  logic [plq_pkg::IdW-1:0] key,
    output plq_pkg::entry_t      entry,
    output logic                 match
);
    plq_pkg::entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (cmd.append && is_tail) begin
            entry_reg <= new_entry;
        end else if (cmd.shift && past_pos) begin
            entry_reg <= right_entry;
        end else if (cmd.write_q && is_pos) begin
            entry_reg.qty <= new_entry.qty;
        end
    end

    assign entry = entry_reg;
    assign match = (entry_reg.id == key);
endmodule

// ===== hw/rtl/price_level_order_queue_core.sv =====
// Price level order queue: up to QUEUE_DEPTH orders held in a chain of slot
// cells in time priority, with a saturating level total. Each accepted request
// passes through a lookup phase that compares the id in every cell at once and
// picks the front-most hit with a priority tree, an apply phase that applies the
// shift, overwrite or append in all cells together, and an output phase in which
// the result beat register is shown. The next request is taken only in the cycle
// after the result beat is accepted, so requests never overlap, and the receiver
// may stall the result beat.
module price_level_order_queue_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [30:0] s_order_id,
    input  logic [31:0] s_order_price,
    input  logic [30:0] s_order_quantity,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [36:0] m_total_quantity,
    output logic [31:0] m_found_price,
    output logic [30:0] m_found_quantity,
    output logic [5:0]  m_found_position,
    output logic [6:0]  m_order_count
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    plq_pkg::phase_t ph_reg, ph_next;
    logic [2:0]  kind_reg;
    plq_pkg::entry_t req_reg;
    logic [CW-1:0] cnt_reg;
    logic [37:0]   tot_reg;
    logic          hit_reg;
    logic [PW-1:0] pos_reg;
    plq_pkg::entry_t hit_entry_reg;

    plq_pkg::entry_t ents [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] match;
    plq_pkg::cell_cmd_t cmd;
    logic [PW-1:0] tail_idx;

    logic [1:0]  st_reg;
    logic [36:0] otot_reg;
    logic [31:0] fp_reg;
    logic [30:0] fq_reg;
    logic [5:0]  fpos_reg;
    logic [6:0]  ocnt_reg;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            plq_pkg::entry_t right;
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign right = ents[g];
            end else begin : g_mid
                assign right = ents[g+1];
            end
            plq_cell u_cell (
                .aclk(aclk),
                .is_pos(pos_reg == PW'(g)),
                .past_pos(PW'(g) >= pos_reg),
                .is_tail(tail_idx == PW'(g)),
                .cmd(cmd),
                .new_entry(req_reg),
                .right_entry(right),
                .key(req_reg.id),
                .entry(ents[g]),
                .match(match[g])
            );
        end
    endgenerate

    // Front-most hit among occupied cells.
    logic          f_hit;
    logic [PW-1:0] f_pos;
    always_comb begin
        f_hit = 1'b0;
        f_pos = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (match[i] && (CW'(i) < cnt_reg)) begin
                f_hit = 1'b1;
                f_pos = PW'(i);
            end
        end
    end

    logic full;
    assign full = (cnt_reg == CW'(QUEUE_DEPTH));

    // Apply decisions.
    logic do_rm, do_wq, do_app, modq_lt, modq_gt, pdiff;
    logic [37:0] plus, minus;
    logic [38:0] tsum;
    logic [37:0] tsat;
    logic [1:0]  st;
    logic [CW-1:0] cnt_n;
    always_comb begin
        pdiff   = req_reg.price != hit_entry_reg.price;
        modq_lt = req_reg.qty < hit_entry_reg.qty;
        modq_gt = req_reg.qty > hit_entry_reg.qty;
        do_rm = 1'b0; do_wq = 1'b0; do_app = 1'b0;
        plus = '0; minus = '0; st = plq_pkg::ST_OK;
        case (kind_reg) inside
            plq_pkg::KIND_ADD: begin
                if (full) st = plq_pkg::ST_FULL;
                else begin do_app = 1'b1; plus = 38'(req_reg.qty); end
            end
            plq_pkg::KIND_REMOVE, plq_pkg::KIND_MODIFY,
            plq_pkg::KIND_DEC, plq_pkg::KIND_FIND: begin
                if (!hit_reg) st = plq_pkg::ST_NOTFOUND;
                else if (kind_reg == plq_pkg::KIND_REMOVE) begin
                    do_rm = 1'b1; minus = 38'(hit_entry_reg.qty);
                end else if (kind_reg == plq_pkg::KIND_MODIFY) begin
                    if (pdiff) begin
                        do_rm = 1'b1; minus = 38'(hit_entry_reg.qty);
                        st = plq_pkg::ST_REMOVED;
                    end else if (modq_lt) begin
                        do_wq = 1'b1; plus = 38'(req_reg.qty);
                        minus = 38'(hit_entry_reg.qty);
                    end else if (modq_gt) begin
                        do_rm = 1'b1; do_app = 1'b1; plus = 38'(req_reg.qty);
                        minus = 38'(hit_entry_reg.qty);
                    end
                end else if (kind_reg == plq_pkg::KIND_DEC) begin
                    do_wq = 1'b1;
                end
            end
            default: ;
        endcase
        tsum = 39'(tot_reg) + 39'(plus);
        if (tsum < 39'(minus)) tsat = '0;
        else if ((tsum - 39'(minus)) > 39'(plq_pkg::TotMax)) tsat = 38'(plq_pkg::TotMax);
        else tsat = 38'(tsum - 39'(minus));
        cnt_n = cnt_reg - CW'(do_rm) + CW'(do_app);
    end

    always_comb begin
        cmd.shift   = (ph_reg == plq_pkg::PH_APPLY) && do_rm;
        cmd.write_q = (ph_reg == plq_pkg::PH_APPLY) && do_wq;
        cmd.append  = (ph_reg == plq_pkg::PH_APPLY) && do_app;
        tail_idx = PW'(cnt_reg - CW'(do_rm));
    end

    always_comb begin
        ph_next = ph_reg;
        unique case (ph_reg)
            plq_pkg::PH_IDLE:   if (s_valid) ph_next = plq_pkg::PH_LOOKUP;
            plq_pkg::PH_LOOKUP: ph_next = plq_pkg::PH_APPLY;
            plq_pkg::PH_APPLY:  ph_next = plq_pkg::PH_OUT;
            plq_pkg::PH_OUT:    if (m_ready) ph_next = plq_pkg::PH_IDLE;
            default:            ph_next = plq_pkg::PH_IDLE;
        endcase
    end

    assign s_ready = (ph_reg == plq_pkg::PH_IDLE);
    assign m_valid = (ph_reg == plq_pkg::PH_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg  <= plq_pkg::PH_IDLE;
            cnt_reg <= '0;
            tot_reg <= '0;
        end else begin
            ph_reg <= ph_next;
            if (ph_reg == plq_pkg::PH_APPLY) begin
                cnt_reg <= cnt_n;
                tot_reg <= tsat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg     <= s_kind;
            req_reg.id   <= s_order_id;
            req_reg.price <= s_order_price;
            req_reg.qty  <= s_order_quantity;
        end
        if (ph_reg == plq_pkg::PH_LOOKUP) begin
            hit_reg       <= f_hit;
            pos_reg       <= f_pos;
            hit_entry_reg <= ents[f_pos];
        end
        if (ph_reg == plq_pkg::PH_APPLY) begin
            st_reg   <= st;
            otot_reg <= tsat[36:0];
            ocnt_reg <= 7'(cnt_n);
            if (kind_reg == plq_pkg::KIND_FIND && hit_reg) begin
                fp_reg   <= hit_entry_reg.price;
                fq_reg   <= hit_entry_reg.qty;
                fpos_reg <= 6'(pos_reg);
            end else begin
                fp_reg <= '0; fq_reg <= '0; fpos_reg <= '0;
            end
        end
    end

    assign m_status         = st_reg;
    assign m_total_quantity = otot_reg;
    assign m_found_price    = fp_reg;
    assign m_found_quantity = fq_reg;
    assign m_found_position = fpos_reg;
    assign m_order_count    = ocnt_reg;
endmodule

// ===== hw/rtl/plq_checker.sv =====
// Port-level checks for the price level order queue core.
// Depends on price_level_order_queue_core; bound to it below.
module plq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [6:0]  m_order_count
);
    // A request is never taken while a result beat waits.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("accept while result pending");
    // Every accepted beat yields a result beat once the lookup and apply phases are done.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##3 m_valid) else $error("result late");
    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("result changed while stalled");
    // A full status comes with a nonzero order count.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == 2'd3) |-> (m_order_count != 7'd0))
        else $error("full with empty queue");
endmodule

bind price_level_order_queue_core plq_checker u_plq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_order_count(m_order_count)
);
